FILE: rtl/usb_midi_event_and_sysex_request_decoder_top_macros.svh
// assertion macros of the usb-midi decoder rtl
`ifndef USB_MIDI_EVENT_AND_SYSEX_REQUEST_DECODER_TOP_MACROS_SVH
`define USB_MIDI_EVENT_AND_SYSEX_REQUEST_DECODER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define UMIDI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define UMIDI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/umidi_pkg.sv
// types and constants of the usb-midi event and sysex request decoder
package umidi_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int HEAD_DEPTH = 5;
	localparam int MIN_MSG_BYTES = 6;

	localparam logic [7:0] SYX_START    = 8'hF0;
	localparam logic [7:0] SYX_END      = 8'hF7;
	localparam logic [7:0] HDR_SYX_CONT = 8'h04;
	localparam logic [7:0] HDR_SYX_END1 = 8'h05;
	localparam logic [7:0] HDR_SYX_END2 = 8'h06;
	localparam logic [7:0] HDR_SYX_END3 = 8'h07;
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAKER_ID        = 3'd0,
		REG_SUB_ID          = 3'd1,
		REG_REQUEST_CODE    = 3'd2,
		REG_FIRST_BLOCK_ID  = 3'd3,
		REG_SECOND_BLOCK_ID = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_NOTE_ON    = 2'd0,
		KIND_NOTE_OFF   = 2'd1,
		KIND_BLOCK1_REQ = 2'd2,
		KIND_BLOCK2_REQ = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] maker_id;
		logic [CFG_DATA_W-1:0] sub_id;
		logic [CFG_DATA_W-1:0] request_code;
		logic [CFG_DATA_W-1:0] first_block_id;
		logic [CFG_DATA_W-1:0] second_block_id;
	} cfg_t;

	typedef struct packed {
		logic [7:0] packet_header;
		logic [7:0] data_byte_a;
		logic [7:0] data_byte_b;
		logic [7:0] data_byte_c;
	} pkt_t;

	typedef struct packed {
		kind_t      event_kind;
		logic [7:0] note_number;
		logic [7:0] note_velocity;
	} evt_t;

endpackage

FILE: rtl/umidi_if.sv
// valid/ready channels for usb-midi packets and decoded events
interface umidi_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_header;
	logic [7:0] data_byte_a;
	logic [7:0] data_byte_b;
	logic [7:0] data_byte_c;

	modport source (output valid, packet_header, data_byte_a, data_byte_b, data_byte_c,
		input ready);
	modport sink (input valid, packet_header, data_byte_a, data_byte_b, data_byte_c,
		output ready);
endinterface

interface umidi_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] note_number;
	logic [7:0] note_velocity;

	modport source (output valid, event_kind, note_number, note_velocity, input ready);
	modport sink (input valid, event_kind, note_number, note_velocity, output ready);
endinterface

FILE: rtl/umidi_cfg_regs.sv
// configuration register bank of the usb-midi decoder
module umidi_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [umidi_pkg::CFG_IDX_W-1:0]  index,
	input  logic [umidi_pkg::CFG_DATA_W-1:0] data,
	output umidi_pkg::cfg_t                cfg
);
	import umidi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.maker_id        <= 7'd125;
			cfg_q.sub_id          <= 7'd0;
			cfg_q.request_code    <= 7'd0;
			cfg_q.first_block_id  <= 7'd1;
			cfg_q.second_block_id <= 7'd2;
		end else if (we) begin
			case (cfg_idx_t'(index))
				REG_MAKER_ID:        cfg_q.maker_id        <= data;
				REG_SUB_ID:          cfg_q.sub_id          <= data;
				REG_REQUEST_CODE:    cfg_q.request_code    <= data;
				REG_FIRST_BLOCK_ID:  cfg_q.first_block_id  <= data;
				REG_SECOND_BLOCK_ID: cfg_q.second_block_id <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/umidi_decode.sv
// sysex collection state and combinational packet decode
module umidi_decode #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  umidi_pkg::cfg_t cfg,
	input  umidi_pkg::pkt_t pkt,
	input  logic            take,
	output logic            hit,
	output umidi_pkg::evt_t evt
);
	import umidi_pkg::*;

	localparam int CntW = $clog2(BUFFER_BYTES + 1);
	localparam logic [CntW:0] BufLim = (CntW + 1)'(BUFFER_BYTES);
	localparam logic [CntW:0] MinLen = (CntW + 1)'(MIN_MSG_BYTES);

	logic            sysex_open_q;
	logic [CntW-1:0] sysex_count_q;
	logic [7:0]      head_q [HEAD_DEPTH];

	logic            start;
	logic            open_eff;
	logic [CntW:0]   cnt_base;
	logic            room2;
	logic            room3;
	logic [1:0]      push_n;
	logic [7:0]      push_byte [3];
	logic            ended;
	logic            open_nx;
	logic [CntW:0]   cnt_sum;
	logic [CntW:0]   cnt_nx;
	logic [7:0]      head_nx [HEAD_DEPTH];
	logic            lead_start;
	logic [7:0]      m_maker;
	logic [7:0]      m_sub;
	logic [7:0]      m_block;
	logic [7:0]      m_type;
	logic            msg_ok;

	always_comb begin
		start    = (pkt.packet_header == HDR_SYX_CONT) && (pkt.data_byte_a == SYX_START);
		open_eff = start || sysex_open_q;
		cnt_base = start ? '0 : {1'b0, sysex_count_q};
		room2    = (cnt_base + (CntW + 1)'(2)) < BufLim;
		room3    = (cnt_base + (CntW + 1)'(3)) < BufLim;

		push_n       = 2'd0;
		push_byte[0] = pkt.data_byte_a;
		push_byte[1] = pkt.data_byte_b;
		push_byte[2] = pkt.data_byte_c;
		ended        = 1'b0;
		open_nx      = sysex_open_q;
		case (pkt.packet_header)
			HDR_SYX_CONT: begin
				open_nx = open_eff;
				if (open_eff && room3) push_n = 2'd3;
			end
			HDR_SYX_END1: begin
				if (sysex_open_q && pkt.data_byte_a == SYX_END) begin
					push_byte[0] = SYX_END;
					push_n = 2'd1;
					ended  = 1'b1;
				end
			end
			HDR_SYX_END2: begin
				if (sysex_open_q && room2) begin
					push_n = 2'd2;
					ended  = 1'b1;
				end
			end
			HDR_SYX_END3: begin
				if (sysex_open_q && room3) begin
					push_n = 2'd3;
					ended  = 1'b1;
				end
			end
			default: ;
		endcase
		if (ended) open_nx = 1'b0;

		// only the single end byte can reach the limit, so clamp there
		cnt_sum = cnt_base + (CntW + 1)'(push_n);
		cnt_nx  = (cnt_sum > BufLim) ? BufLim : cnt_sum;

		for (int i = 0; i < HEAD_DEPTH; i++) begin
			head_nx[i] = head_q[i];
			for (int j = 0; j < 3; j++) begin
				if ((2'(j) < push_n) && ((cnt_base + (CntW + 1)'(j)) == (CntW + 1)'(i)))
					head_nx[i] = push_byte[j];
			end
		end

		// skip a leading start byte before the id fields
		lead_start = (head_nx[0] == SYX_START);
		m_maker = lead_start ? head_nx[1] : head_nx[0];
		m_sub   = lead_start ? head_nx[2] : head_nx[1];
		m_block = lead_start ? head_nx[3] : head_nx[2];
		m_type  = lead_start ? head_nx[4] : head_nx[3];
		msg_ok  = ended && (cnt_nx >= MinLen)
			&& (m_maker == {1'b0, cfg.maker_id})
			&& (m_sub == {1'b0, cfg.sub_id})
			&& (m_type == {1'b0, cfg.request_code});

		hit               = 1'b0;
		evt.event_kind    = KIND_NOTE_ON;
		evt.note_number   = 8'd0;
		evt.note_velocity = 8'd0;
		case (pkt.packet_header)
			HDR_SYX_CONT, HDR_SYX_END1, HDR_SYX_END2, HDR_SYX_END3: begin
				if (msg_ok && m_block == {1'b0, cfg.first_block_id}) begin
					hit = 1'b1;
					evt.event_kind = KIND_BLOCK1_REQ;
				end else if (msg_ok && m_block == {1'b0, cfg.second_block_id}) begin
					hit = 1'b1;
					evt.event_kind = KIND_BLOCK2_REQ;
				end
			end
			default: begin
				if (pkt.data_byte_a[7:4] == STATUS_NOTE_ON) begin
					hit               = 1'b1;
					evt.event_kind    = (pkt.data_byte_c != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
					evt.note_number   = pkt.data_byte_b;
					evt.note_velocity = pkt.data_byte_c;
				end else if (pkt.data_byte_a[7:4] == STATUS_NOTE_OFF) begin
					hit             = 1'b1;
					evt.event_kind  = KIND_NOTE_OFF;
					evt.note_number = pkt.data_byte_b;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysex_open_q  <= 1'b0;
			sysex_count_q <= '0;
		end else if (take) begin
			sysex_open_q  <= open_nx;
			sysex_count_q <= cnt_nx[CntW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < HEAD_DEPTH; i++) head_q[i] <= head_nx[i];
		end
	end

endmodule

FILE: rtl/usb_midi_event_and_sysex_request_decoder_top.sv
// Decodes one four-byte usb-midi event packet per cycle into note on/off events and
// sysex block one/two request events. A packet is taken into an input register, decoded
// and folded into the sysex state in one pass, and its event, if any, lands in a result
// register when the input register advances; packets with no event are simply consumed.
// Sustained rate is one packet per clock, set by the single decode stage; the input side
// keeps accepting while a finished event waits, and stalls only when a new event meets a
// full result register. Configuration is written through cfg_we/cfg_index/cfg_data.
`include "usb_midi_event_and_sysex_request_decoder_top_macros.svh"

module usb_midi_event_and_sysex_request_decoder_top #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	umidi_pkt_if.sink                       pkt,
	umidi_evt_if.source                     evt,
	input  logic                            cfg_we,
	input  logic [umidi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [umidi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import umidi_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	pkt_t pkt_s1;
	logic hit;
	evt_t evt_nx;
	logic advance;
	logic evt_valid_q;
	evt_t evt_q;

	umidi_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	umidi_decode #(.BUFFER_BYTES(BUFFER_BYTES)) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pkt    (pkt_s1),
		.take   (advance),
		.hit    (hit),
		.evt    (evt_nx)
	);

	// an item with no event never waits on the result register
	assign advance   = valid_s1 && (!hit || !evt_valid_q || evt.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			pkt_s1.packet_header <= pkt.packet_header;
			pkt_s1.data_byte_a   <= pkt.data_byte_a;
			pkt_s1.data_byte_b   <= pkt.data_byte_b;
			pkt_s1.data_byte_c   <= pkt.data_byte_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (advance && hit) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) evt_q <= evt_nx;
	end

	assign evt.valid         = evt_valid_q;
	assign evt.event_kind    = evt_q.event_kind;
	assign evt.note_number   = evt_q.note_number;
	assign evt.note_velocity = evt_q.note_velocity;

	`UMIDI_ASSERT_NOW(a_req_no_note, evt.valid && (evt.event_kind == KIND_BLOCK1_REQ || evt.event_kind == KIND_BLOCK2_REQ), evt.note_number == 8'd0 && evt.note_velocity == 8'd0, "request item carries note data")
	`UMIDI_ASSERT_NOW(a_off_no_vel, evt.valid && evt.event_kind == KIND_NOTE_OFF, evt.note_velocity == 8'd0, "note off item carries velocity")
	`UMIDI_ASSERT_NEXT(a_accept_loads, pkt.valid && pkt.ready, valid_s1, "accepted item not in input register")
	`UMIDI_ASSERT_NEXT(a_stall_holds, valid_s1 && !advance, valid_s1 && $stable(pkt_s1), "stalled input register changed")

endmodule
